@@ hdl/btmx_pkg.sv @@
package btmx_pkg;

    localparam int KEY_BITS = 31;
    localparam int KEY_MSB = KEY_BITS - 1;
    localparam int NEED_W = $clog2(KEY_BITS + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0] value;
        logic                first;
    } t_in;

    typedef struct packed {
        logic [KEY_BITS-1:0] best_xor;
        logic [KEY_BITS-1:0] running_max;
        logic                had_partner;
        logic                store_full;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_FILL
    } t_state;

endpackage

@@ hdl/btmx_ram.sv @@
module btmx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hdl/btmx_cell.sv @@
module btmx_cell import btmx_pkg::*; #(
    parameter int NODE_COUNT = 4096,
    parameter int POS = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic                          i_root_null,
    input  logic [$clog2(NODE_COUNT)-1:0] i_sa,
    input  logic [$clog2(NODE_COUNT)-1:0] i_ia,
    input  logic [2*$clog2(NODE_COUNT)+KEY_BITS+NEED_W+2:0] i_find,
    input  logic [3*$clog2(NODE_COUNT)+1:0] i_fill,
    output logic [$clog2(NODE_COUNT)-1:0] o_sa,
    output logic [$clog2(NODE_COUNT)-1:0] o_ia,
    output logic [2*$clog2(NODE_COUNT)+KEY_BITS+NEED_W+2:0] o_find,
    output logic [3*$clog2(NODE_COUNT)+1:0] o_fill
);

    localparam int IDW = $clog2(NODE_COUNT);

    typedef struct packed {
        logic                valid;
        logic                s_live;
        logic                i_live;
        logic [IDW-1:0]      i_node;
        logic [IDW-1:0]      spare;
        logic [KEY_BITS-1:0] acc;
        logic [NEED_W-1:0]   need;
    } t_find;

    typedef struct packed {
        logic           valid;
        logic           act;
        logic [IDW-1:0] cur;
        logic [IDW-1:0] nxt;
        logic [IDW-1:0] spare;
    } t_fill;

    typedef struct packed {
        logic [IDW-1:0] zero;
        logic [IDW-1:0] one;
    } t_link;

    t_find          w_find_in;
    t_fill          w_fill_in;
    t_find          n_find;
    t_find          r_find;
    t_fill          n_fill;
    t_fill          r_fill;
    t_link          w_ram_s;
    t_link          w_ram_i;
    t_link          w_rd_s;
    t_link          w_rd_i;
    t_link          w_wdata;
    logic [IDW-1:0] w_s_other;
    logic [IDW-1:0] w_s_same;
    logic [IDW-1:0] w_i_next;
    logic [IDW-1:0] w_keep;
    logic [IDW-1:0] w_waddr;
    logic           w_bit;
    logic           w_brk;
    logic           w_we;
    logic [IDW-1:0] n_sa;
    logic [IDW-1:0] n_ia;
    logic           r_brk;
    logic [IDW-1:0] r_node;
    logic [IDW-1:0] r_keep;

    assign w_find_in = i_find;
    assign w_fill_in = i_fill;

    btmx_ram #(
        .WIDTH (2 * IDW),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (i_sa),
        .i_raddr_b (i_ia),
        .o_rdata_a (w_ram_s),
        .o_rdata_b (w_ram_i)
    );

    assign w_bit  = i_key[POS];
    assign w_rd_s = i_root_null ? '0 : w_ram_s;
    assign w_rd_i = i_root_null ? '0 : w_ram_i;

    assign w_s_other = w_bit ? w_rd_s.zero : w_rd_s.one;
    assign w_s_same  = w_bit ? w_rd_s.one : w_rd_s.zero;
    assign w_i_next  = w_bit ? w_rd_i.one : w_rd_i.zero;
    assign w_brk     = w_find_in.i_live && (w_i_next == '0);

    always_comb begin
        n_find = w_find_in;
        n_sa   = '0;
        n_ia   = '0;
        if (w_find_in.s_live) begin
            if (w_s_other != '0) begin
                n_find.acc[POS] = 1'b1;
                n_sa = w_s_other;
            end else if (w_s_same != '0) begin
                n_sa = w_s_same;
            end else begin
                n_find.s_live = 1'b0;
            end
        end
        if (w_find_in.i_live && !w_brk) begin
            n_ia          = w_i_next;
            n_find.i_node = w_i_next;
        end else begin
            n_find.i_live = 1'b0;
            n_find.need   = w_find_in.need + NEED_W'(1);
        end
    end

    // The fill beat writes the break node here, or the fresh node handed down.
    assign w_keep  = r_brk ? r_keep : '0;
    assign w_we    = w_fill_in.valid && (r_brk || w_fill_in.act);
    assign w_waddr = r_brk ? r_node : w_fill_in.cur;
    assign w_wdata = w_bit ? t_link'{zero: w_keep, one: w_fill_in.nxt}
                           : t_link'{zero: w_fill_in.nxt, one: w_keep};

    always_comb begin
        n_fill = w_fill_in;
        if (w_we) begin
            n_fill.act = 1'b1;
            n_fill.cur = w_fill_in.nxt;
            n_fill.nxt = w_fill_in.nxt + IDW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find.valid <= 1'b0;
            r_fill.valid <= 1'b0;
            r_brk        <= 1'b0;
        end else begin
            r_find.valid <= n_find.valid;
            r_fill.valid <= n_fill.valid;
            if (w_find_in.valid) begin
                r_brk <= w_brk;
            end
        end
        r_find.s_live <= n_find.s_live;
        r_find.i_live <= n_find.i_live;
        r_find.i_node <= n_find.i_node;
        r_find.spare  <= n_find.spare;
        r_find.acc    <= n_find.acc;
        r_find.need   <= n_find.need;
        r_fill.act    <= n_fill.act;
        r_fill.cur    <= n_fill.cur;
        r_fill.nxt    <= n_fill.nxt;
        r_fill.spare  <= n_fill.spare;
        if (w_find_in.valid) begin
            r_node <= w_find_in.i_node;
            r_keep <= w_bit ? w_rd_i.zero : w_rd_i.one;
        end
    end

    assign o_sa   = n_sa;
    assign o_ia   = n_ia;
    assign o_find = r_find;
    assign o_fill = r_fill;

endmodule

@@ hdl/binary_trie_max_xor.sv @@
// Channel   Direction  Handshake             Beat
// item      in         start high, busy low  i_item (value, first)
// result    out        o_valid, one cycle    o_result (best_xor, running_max,
//                                            had_partner, store_full)
//
// A search beat walks the row of level cells, one trie level per cycle, and the
// result strobe follows the search beat out of the last cell. When the key is
// inserted, a fill beat then walks the same row to write the new links, and
// busy stays high until the fill beat leaves the last cell; when the insert is
// dropped busy falls as the result strobe is raised. The synchronous reset
// empties the trie at once; the receiver cannot stall.
module binary_trie_max_xor import btmx_pkg::*; #(
    parameter int NODE_COUNT = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    localparam int IDW = $clog2(NODE_COUNT);
    localparam int UW  = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic                valid;
        logic                s_live;
        logic                i_live;
        logic [IDW-1:0]      i_node;
        logic [IDW-1:0]      spare;
        logic [KEY_BITS-1:0] acc;
        logic [NEED_W-1:0]   need;
    } t_find;

    typedef struct packed {
        logic           valid;
        logic           act;
        logic [IDW-1:0] cur;
        logic [IDW-1:0] nxt;
        logic [IDW-1:0] spare;
    } t_fill;

    t_state              r_state;
    t_state              n_state;
    logic [UW-1:0]       r_used;
    logic [UW-1:0]       n_used;
    logic                r_nonempty;
    logic                n_nonempty;
    logic [KEY_BITS-1:0] r_max;
    logic [KEY_BITS-1:0] n_max;
    logic                r_root_ok;
    logic                n_root_ok;
    logic                r_partner;
    logic                n_partner;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    t_find               r_find0;
    t_find               n_find0;
    t_fill               r_fill0;
    t_fill               n_fill0;
    logic                r_strobe;
    logic                n_strobe;
    t_out                r_res;
    t_out                n_res;
    logic                w_accept;
    t_find               w_last;
    t_fill               w_last_fill;
    logic [KEY_BITS-1:0] w_best;
    logic [UW-1:0]       w_free;
    logic [UW-1:0]       w_need;
    logic                w_fit;

    t_find          w_find [KEY_BITS+1];
    t_fill          w_fill [KEY_BITS+1];
    logic [IDW-1:0] w_sa   [KEY_BITS+1];
    logic [IDW-1:0] w_ia   [KEY_BITS+1];

    assign w_find[0] = r_find0;
    assign w_fill[0] = r_fill0;
    assign w_sa[0]   = '0;
    assign w_ia[0]   = '0;

    for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
        btmx_cell #(
            .NODE_COUNT (NODE_COUNT),
            .POS        (KEY_MSB - g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (r_key),
            .i_root_null ((g == 0) ? !r_root_ok : 1'b0),
            .i_sa        (w_sa[g]),
            .i_ia        (w_ia[g]),
            .i_find      (w_find[g]),
            .i_fill      (w_fill[g]),
            .o_sa        (w_sa[g+1]),
            .o_ia        (w_ia[g+1]),
            .o_find      (w_find[g+1]),
            .o_fill      (w_fill[g+1])
        );
    end

    assign w_accept    = start && !busy;
    assign w_last      = w_find[KEY_BITS];
    assign w_last_fill = w_fill[KEY_BITS];
    assign w_best      = r_partner ? w_last.acc : '0;
    assign w_free      = UW'(NODE_COUNT) - r_used;
    assign w_need      = {{(UW - NEED_W){1'b0}}, w_last.need};
    assign w_fit       = w_need <= w_free;

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_nonempty = r_nonempty;
        n_max      = r_max;
        n_root_ok  = r_root_ok;
        n_partner  = r_partner;
        n_key      = r_key;
        n_find0    = r_find0;
        n_fill0    = r_fill0;
        n_strobe   = 1'b0;
        n_res      = r_res;
        n_find0.valid = 1'b0;
        n_fill0.valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_key     = i_item.value;
                    n_partner = r_nonempty && !i_item.first;
                    if (i_item.first) begin
                        n_used     = UW'(1);
                        n_nonempty = 1'b0;
                        n_max      = '0;
                        n_root_ok  = 1'b0;
                    end
                    n_find0 = '{valid: 1'b1, s_live: r_nonempty && !i_item.first,
                                i_live: 1'b1, i_node: '0, spare: '0, acc: '0,
                                need: '0};
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                if (w_last.valid) begin
                    if (w_best > r_max) begin
                        n_max = w_best;
                    end
                    n_res.best_xor    = w_best;
                    n_res.running_max = (w_best > r_max) ? w_best : r_max;
                    n_res.had_partner = r_partner;
                    n_res.store_full  = !w_fit;
                    n_strobe          = 1'b1;
                    if (w_fit) begin
                        n_used     = r_used + w_need;
                        n_nonempty = 1'b1;
                        n_root_ok  = 1'b1;
                        n_fill0    = '{valid: 1'b1, act: 1'b0, cur: '0,
                                       nxt: r_used[IDW-1:0], spare: '0};
                        n_state    = ST_FILL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FILL: begin
                if (w_last_fill.valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_used        <= UW'(1);
            r_nonempty    <= 1'b0;
            r_max         <= '0;
            r_root_ok     <= 1'b0;
            r_find0.valid <= 1'b0;
            r_fill0.valid <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_used        <= n_used;
            r_nonempty    <= n_nonempty;
            r_max         <= n_max;
            r_root_ok     <= n_root_ok;
            r_find0.valid <= n_find0.valid;
            r_fill0.valid <= n_fill0.valid;
            r_strobe      <= n_strobe;
        end
        r_partner      <= n_partner;
        r_key          <= n_key;
        r_res          <= n_res;
        r_find0.s_live <= n_find0.s_live;
        r_find0.i_live <= n_find0.i_live;
        r_find0.i_node <= n_find0.i_node;
        r_find0.spare  <= n_find0.spare;
        r_find0.acc    <= n_find0.acc;
        r_find0.need   <= n_find0.need;
        r_fill0.act    <= n_fill0.act;
        r_fill0.cur    <= n_fill0.cur;
        r_fill0.nxt    <= n_fill0.nxt;
        r_fill0.spare  <= n_fill0.spare;
    end

    assign busy     = r_state != ST_IDLE;
    assign o_valid  = r_strobe;
    assign o_result = r_res;

endmodule

@@ verif/binary_trie_max_xor_tb.sv @@
`timescale 1ns / 100ps

module binary_trie_max_xor_tb;
    import btmx_pkg::*;

    localparam int TRIE_NODES = 4096;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [KEY_BITS-1:0] ALL_ONES = {KEY_BITS{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_valid;
    t_out o_result;

    binary_trie_max_xor #(.NODE_COUNT(TRIE_NODES)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    int unsigned zero_link [TRIE_NODES];
    int unsigned one_link [TRIE_NODES];
    int unsigned nodes_taken;
    bit set_has_keys;
    logic [KEY_BITS-1:0] set_best;
    logic [KEY_BITS-1:0] stored_keys [$];

    t_out xor_results_due [$];
    t_out last_prediction;
    int mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit gaps_on = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void trie_clear();
        nodes_taken = 1;
        zero_link[0] = 0;
        one_link[0] = 0;
        set_has_keys = 1'b0;
        set_best = '0;
        stored_keys.delete();
    endfunction

    function automatic int unsigned trie_link(int unsigned node, bit dir);
        return dir ? one_link[node] : zero_link[node];
    endfunction

    function automatic logic [KEY_BITS-1:0] trie_search(logic [KEY_BITS-1:0] key);
        int unsigned node = 0;
        int unsigned other;
        int unsigned same;
        logic [KEY_BITS-1:0] acc = '0;
        for (int k = KEY_MSB; k >= 0; k--) begin
            other = trie_link(node, !key[k]);
            same = trie_link(node, key[k]);
            acc = {acc[KEY_BITS-2:0], 1'b0};
            if (other != 0) begin
                acc[0] = 1'b1;
                node = other;
            end else if (same != 0) begin
                node = same;
            end
        end
        return acc;
    endfunction

    // The key goes in whole or not at all.
    function automatic bit trie_insert(logic [KEY_BITS-1:0] key);
        int unsigned node = 0;
        int unsigned next_node;
        int depth = KEY_MSB;
        while (depth >= 0) begin
            next_node = trie_link(node, key[depth]);
            if (next_node == 0) begin
                break;
            end
            node = next_node;
            depth--;
        end
        if (depth + 1 > TRIE_NODES - int'(nodes_taken)) begin
            return 1'b0;
        end
        for (int k = depth; k >= 0; k--) begin
            zero_link[nodes_taken] = 0;
            one_link[nodes_taken] = 0;
            if (key[k]) begin
                one_link[node] = nodes_taken;
            end else begin
                zero_link[node] = nodes_taken;
            end
            node = nodes_taken;
            nodes_taken++;
        end
        return 1'b1;
    endfunction

    function automatic t_out predict_max_xor(t_in item);
        t_out res;
        if (item.first) begin
            trie_clear();
        end
        res.had_partner = set_has_keys;
        res.best_xor = '0;
        if (set_has_keys) begin
            res.best_xor = trie_search(item.value);
            if (res.best_xor > set_best) begin
                set_best = res.best_xor;
            end
        end
        res.store_full = !trie_insert(item.value);
        if (!res.store_full) begin
            set_has_keys = 1'b1;
            stored_keys.push_back(item.value);
        end
        res.running_max = set_best;
        return res;
    endfunction

    // A beat is taken at the edge where start is high and busy is low.
    task automatic send_key(input logic [KEY_BITS-1:0] key, input bit new_set);
        t_in item;
        item.value = key;
        item.first = new_set;
        i_item <= item;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        last_prediction = predict_max_xor(item);
        xor_results_due.push_back(last_prediction);
    endtask

    task automatic idle_gap();
        if (!gaps_on || $urandom_range(0, 2) == 0) begin
            return;
        end
        start <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
        end
        repeat ($urandom_range(1, 9)) @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        while (xor_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string field, input logic [KEY_BITS-1:0] want_v,
                                input logic [KEY_BITS-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, field, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (xor_results_due.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %h", $time, o_result);
                mismatch_count++;
            end else begin
                want = xor_results_due.pop_front();
                report_field("best_xor", want.best_xor, o_result.best_xor);
                report_field("running_max", want.running_max, o_result.running_max);
                report_field("had_partner", KEY_BITS'(want.had_partner),
                             KEY_BITS'(o_result.had_partner));
                report_field("store_full", KEY_BITS'(want.store_full),
                             KEY_BITS'(o_result.store_full));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_edge_keys();
        send_key('0, 1'b0);
        send_key(ALL_ONES, 1'b0);
        send_key('0, 1'b0);
        send_key(ALL_ONES, 1'b0);
        send_key(31'h5555_5555, 1'b0);
        send_key(31'h4000_0000, 1'b1);
        send_key(31'h0000_0001, 1'b0);
        send_key(31'h4000_0001, 1'b0);
        send_key(31'h2AAA_AAAA, 1'b0);
        send_key(31'h5555_5555, 1'b0);
        send_key('0, 1'b0);
        send_key(ALL_ONES, 1'b1);
        send_key(31'h1234_5678, 1'b1);
        send_key(31'h7FFF_FFFE, 1'b1);
        send_key(ALL_ONES, 1'b0);
    endtask

    task automatic test_duplicate_keys();
        logic [KEY_BITS-1:0] key;
        key = KEY_BITS'($urandom);
        wait_results_drained();
        send_key(key, 1'b1);
        repeat (4) begin
            send_key(key, 1'b0);
            idle_gap();
        end
        send_key(key ^ 31'h1, 1'b0);
    endtask

    task automatic test_store_full();
        int dropped = 0;
        int tries = 0;
        logic [KEY_BITS-1:0] key;
        wait_results_drained();
        send_key(KEY_BITS'($urandom), 1'b1);
        while (dropped < 8 && tries < 600) begin
            send_key(KEY_BITS'($urandom), 1'b0);
            if (last_prediction.store_full) begin
                dropped++;
            end
            tries++;
            idle_gap();
        end
        repeat (12) begin
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            if ($urandom_range(0, 1) == 1) begin
                key = key ^ (ALL_ONES >> $urandom_range(KEY_BITS - 3, KEY_BITS - 1));
            end
            send_key(key, 1'b0);
            idle_gap();
        end
    endtask

    task automatic test_random_sets(input int total);
        int sent = 0;
        int set_size;
        int spread;
        bit new_set;
        logic [KEY_BITS-1:0] base;
        logic [KEY_BITS-1:0] key;
        while (sent < total) begin
            set_size = $urandom_range(1, 40);
            spread = $urandom_range(1, KEY_BITS);
            base = KEY_BITS'($urandom);
            gaps_on = (total - sent > 60) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < set_size && sent < total; n++) begin
                key = base ^ (KEY_BITS'($urandom) & (ALL_ONES >> (KEY_BITS - spread)));
                if (stored_keys.size() != 0 && $urandom_range(0, 7) == 0) begin
                    key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                end
                new_set = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 30) == 0);
                send_key(key, new_set);
                sent++;
                if (gaps_on && $urandom_range(0, 60) == 0) begin
                    wait_results_drained();
                end else begin
                    idle_gap();
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        trie_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_keys();
        test_duplicate_keys();
        test_store_full();
        test_random_sets(200);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ binary_trie_max_xor.f @@
hdl/btmx_pkg.sv
hdl/btmx_ram.sv
hdl/btmx_cell.sv
hdl/binary_trie_max_xor.sv
verif/binary_trie_max_xor_tb.sv
